[hw/rtl/wsde_pkg.sv]
`default_nettype none

package wsde_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_WORKERS_DEF = 4;
    localparam int DEQUE_DEPTH_DEF = 16;
    localparam int JOB_ID_BITS_DEF = 10;

    // Depth of the command queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 2;

    // Fixed field widths.
    localparam int REQ_W     = 2;
    localparam int QSEL_W    = 3;
    localparam int WRK_W     = 2;
    localparam int SRC_W     = 2;
    localparam int STS_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;
    localparam int THR_W     = 4;
    localparam int WIU_W     = 3;
    localparam int OP_W      = 3;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_PUSH_TAIL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_HEAD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_GET_WORK  = 2'd2;

    // Result sources.
    localparam logic [SRC_W-1:0] SRC_OWN     = 2'd0;
    localparam logic [SRC_W-1:0] SRC_STOLEN  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_ARRIVAL = 2'd2;
    localparam logic [SRC_W-1:0] SRC_NONE    = 2'd3;

    // Result status codes.
    localparam logic [STS_W-1:0] STS_DONE    = 2'd0;
    localparam logic [STS_W-1:0] STS_NO_WORK = 2'd1;
    localparam logic [STS_W-1:0] STS_REJECT  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEAL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKERS_IN_USE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVAL_ENABLE  = 2'd2;

    // Configuration reset values.
    localparam logic [THR_W-1:0] STEAL_THR_RST      = 4'd1;
    localparam logic [WIU_W-1:0] WORKERS_IN_USE_RST = 3'd4;

    // Decoded operations handed from the front end to the back end.
    localparam logic [OP_W-1:0] OP_NOP       = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd2;
    localparam logic [OP_W-1:0] OP_GET       = 3'd3;
    localparam logic [OP_W-1:0] OP_REJECT    = 3'd4;
    localparam logic [OP_W-1:0] OP_NO_WORK   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            steal_ok;
    } t_ctl;

endpackage

`default_nettype wire

[hw/rtl/wsde_front.sv]
`default_nettype none

module wsde_front #(
    parameter int NUM_WORKERS = wsde_pkg::NUM_WORKERS_DEF,
    parameter int JOB_ID_BITS = wsde_pkg::JOB_ID_BITS_DEF
) (
    input  wire logic [wsde_pkg::REQ_W-1:0]           i_req_type,
    input  wire logic [wsde_pkg::QSEL_W-1:0]          i_queue_sel,
    input  wire logic [JOB_ID_BITS-1:0]               i_job_id,
    input  wire logic [wsde_pkg::WRK_W-1:0]           i_worker,
    input  wire logic [wsde_pkg::WRK_W-1:0]           i_victim,
    output wsde_pkg::t_ctl                            o_ctl,
    output logic [$clog2(NUM_WORKERS+1)-1:0]          o_q,
    output logic [$clog2(NUM_WORKERS+1)-1:0]          o_vic,
    output logic [JOB_ID_BITS-1:0]                    o_job
);

    localparam int QIDX_W = $clog2(NUM_WORKERS + 1);

    logic qsel_ok;
    logic worker_ok;
    logic victim_ok;

    // Index checks that need no deque state are settled here.
    assign qsel_ok   = 32'(i_queue_sel) <= 32'(NUM_WORKERS);
    assign worker_ok = 32'(i_worker) < 32'(NUM_WORKERS);
    assign victim_ok = 32'(i_victim) < 32'(NUM_WORKERS);

    assign o_vic = QIDX_W'(i_victim);
    assign o_job = i_job_id;

    always_comb begin
        o_ctl.steal_ok = victim_ok && (i_victim != i_worker);
        o_ctl.op       = wsde_pkg::OP_NOP;
        o_q            = QIDX_W'(i_queue_sel);
        case (i_req_type)
            wsde_pkg::REQ_PUSH_TAIL: begin
                o_ctl.op = qsel_ok ? wsde_pkg::OP_PUSH_TAIL : wsde_pkg::OP_REJECT;
            end
            wsde_pkg::REQ_PUSH_HEAD: begin
                o_ctl.op = qsel_ok ? wsde_pkg::OP_PUSH_HEAD : wsde_pkg::OP_REJECT;
            end
            wsde_pkg::REQ_GET_WORK: begin
                o_ctl.op = worker_ok ? wsde_pkg::OP_GET : wsde_pkg::OP_NO_WORK;
                o_q      = QIDX_W'(i_worker);
            end
            default: begin
                o_ctl.op = wsde_pkg::OP_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/wsde_fifo.sv]
`default_nettype none

module wsde_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = wsde_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_buf[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/wsde_back.sv]
`default_nettype none

module wsde_back #(
    parameter int NUM_WORKERS = wsde_pkg::NUM_WORKERS_DEF,
    parameter int DEQUE_DEPTH = wsde_pkg::DEQUE_DEPTH_DEF,
    parameter int JOB_ID_BITS = wsde_pkg::JOB_ID_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    input  wire logic [wsde_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [wsde_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  wire logic                                i_cmd_valid,
    output logic                                     o_cmd_pop,
    input  wsde_pkg::t_ctl                           i_ctl,
    input  wire logic [$clog2(NUM_WORKERS+1)-1:0]    i_q,
    input  wire logic [$clog2(NUM_WORKERS+1)-1:0]    i_vic,
    input  wire logic [JOB_ID_BITS-1:0]              i_job,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [JOB_ID_BITS-1:0]                   o_job,
    output logic [wsde_pkg::SRC_W-1:0]               o_source,
    output logic [wsde_pkg::STS_W-1:0]               o_status
);

    localparam int NUM_DEQ   = NUM_WORKERS + 1;
    localparam int QIDX_W    = $clog2(NUM_DEQ);
    localparam int HEAD_W    = $clog2(DEQUE_DEPTH);
    localparam int CNT_W     = $clog2(DEQUE_DEPTH + 1);
    localparam int POS_W     = CNT_W + 1;
    localparam int MEM_DEPTH = NUM_DEQ * DEQUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CMP_W     = (CNT_W > wsde_pkg::THR_W) ? CNT_W : wsde_pkg::THR_W;

    localparam logic [QIDX_W-1:0] ARR_Q    = QIDX_W'(NUM_WORKERS);
    localparam logic [ADDR_W-1:0] ARR_BASE = ADDR_W'(NUM_WORKERS * DEQUE_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_STEAL = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    // Ring position modulo the deque depth; the sum is always below twice the depth.
    function automatic logic [HEAD_W-1:0] wrap_pos(input logic [POS_W-1:0] s);
        logic [POS_W-1:0] t;
        t = (s >= POS_W'(DEQUE_DEPTH)) ? s - POS_W'(DEQUE_DEPTH) : s;
        return t[HEAD_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] mem_base(input logic [QIDX_W-1:0] q);
        return ADDR_W'(q) * ADDR_W'(DEQUE_DEPTH);
    endfunction

    logic [JOB_ID_BITS-1:0]       r_mem [MEM_DEPTH];
    logic [JOB_ID_BITS-1:0]       r_mem_q;
    logic [HEAD_W-1:0]            r_head [NUM_DEQ];
    logic [CNT_W-1:0]             r_cnt [NUM_DEQ];

    logic [wsde_pkg::THR_W-1:0]   r_thr;
    logic [wsde_pkg::WIU_W-1:0]   r_wiu;
    logic                         r_arr_en;

    logic [1:0]                   r_state;
    logic [1:0]                   n_state;
    logic [QIDX_W-1:0]            r_vic;
    logic [QIDX_W-1:0]            n_vic;
    logic                         r_steal_ok;
    logic                         n_steal_ok;
    logic [wsde_pkg::SRC_W-1:0]   r_src;
    logic [wsde_pkg::SRC_W-1:0]   n_src;

    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [JOB_ID_BITS-1:0]       r_out_job;
    logic [JOB_ID_BITS-1:0]       n_out_job;
    logic [wsde_pkg::SRC_W-1:0]   r_out_src;
    logic [wsde_pkg::SRC_W-1:0]   n_out_src;
    logic [wsde_pkg::STS_W-1:0]   r_out_sts;
    logic [wsde_pkg::STS_W-1:0]   n_out_sts;

    logic [QIDX_W-1:0]            sel;
    logic [HEAD_W-1:0]            head_sel;
    logic [CNT_W-1:0]             cnt_sel;
    logic [HEAD_W-1:0]            head_arr;
    logic [CNT_W-1:0]             cnt_arr;
    logic                         slot_free;
    logic                         go;

    logic                         mem_we;
    logic                         mem_re;
    logic [ADDR_W-1:0]            mem_addr;
    logic                         upd_en;
    logic [QIDX_W-1:0]            upd_q;
    logic [HEAD_W-1:0]            upd_head;
    logic [CNT_W-1:0]             upd_cnt;
    logic [HEAD_W-1:0]            head_dec;

    // One selected deque per cycle: the command's own queue, or the victim.
    assign sel       = (r_state == ST_STEAL) ? r_vic : i_q;
    assign head_sel  = r_head[sel];
    assign cnt_sel   = r_cnt[sel];
    assign head_arr  = r_head[ARR_Q];
    assign cnt_arr   = r_cnt[ARR_Q];
    assign head_dec  = (head_sel == '0) ? HEAD_W'(DEQUE_DEPTH - 1) : head_sel - HEAD_W'(1);

    // A command starts only when the result register will be free for it.
    assign slot_free = !r_out_valid || !i_stall;
    assign go        = (r_state == ST_IDLE) && i_cmd_valid && slot_free;
    assign o_cmd_pop = go;

    assign o_valid  = r_out_valid;
    assign o_job    = r_out_job;
    assign o_source = r_out_src;
    assign o_status = r_out_sts;

    always_comb begin
        n_state     = r_state;
        n_vic       = r_vic;
        n_steal_ok  = r_steal_ok;
        n_src       = r_src;
        n_out_valid = r_out_valid && i_stall;
        n_out_job   = r_out_job;
        n_out_src   = r_out_src;
        n_out_sts   = r_out_sts;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = '0;
        upd_en      = 1'b0;
        upd_q       = sel;
        upd_head    = head_sel;
        upd_cnt     = cnt_sel;

        case (r_state)
            ST_IDLE: begin
                if (go) begin
                    n_out_job = '0;
                    n_out_src = wsde_pkg::SRC_NONE;
                    n_out_sts = wsde_pkg::STS_DONE;
                    case (i_ctl.op)
                        wsde_pkg::OP_PUSH_TAIL, wsde_pkg::OP_PUSH_HEAD: begin
                            n_out_valid = 1'b1;
                            if (cnt_sel >= CNT_W'(DEQUE_DEPTH)) begin
                                n_out_sts = wsde_pkg::STS_REJECT;
                            end else begin
                                mem_we  = 1'b1;
                                upd_en  = 1'b1;
                                upd_cnt = cnt_sel + CNT_W'(1);
                                if (i_ctl.op == wsde_pkg::OP_PUSH_TAIL) begin
                                    mem_addr = mem_base(sel) + ADDR_W'(wrap_pos(
                                        POS_W'(head_sel) + POS_W'(cnt_sel)));
                                end else begin
                                    upd_head = head_dec;
                                    mem_addr = mem_base(sel) + ADDR_W'(head_dec);
                                end
                            end
                        end
                        wsde_pkg::OP_GET: begin
                            if (cnt_sel != '0) begin
                                mem_re   = 1'b1;
                                mem_addr = mem_base(sel) + ADDR_W'(wrap_pos(
                                    POS_W'(head_sel) + POS_W'(cnt_sel) - POS_W'(1)));
                                upd_en   = 1'b1;
                                upd_cnt  = cnt_sel - CNT_W'(1);
                                n_src    = wsde_pkg::SRC_OWN;
                                n_state  = ST_READ;
                            end else begin
                                n_vic      = i_vic;
                                n_steal_ok = i_ctl.steal_ok;
                                n_state    = ST_STEAL;
                            end
                        end
                        wsde_pkg::OP_REJECT: begin
                            n_out_valid = 1'b1;
                            n_out_sts   = wsde_pkg::STS_REJECT;
                        end
                        wsde_pkg::OP_NO_WORK: begin
                            n_out_valid = 1'b1;
                            n_out_sts   = wsde_pkg::STS_NO_WORK;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_STEAL: begin
                if (r_steal_ok && (r_wiu > wsde_pkg::WIU_W'(1)) &&
                    (CMP_W'(cnt_sel) > CMP_W'(r_thr))) begin
                    mem_re   = 1'b1;
                    mem_addr = mem_base(sel) + ADDR_W'(head_sel);
                    upd_en   = 1'b1;
                    upd_head = (head_sel == HEAD_W'(DEQUE_DEPTH - 1)) ? '0
                                                                      : head_sel + HEAD_W'(1);
                    upd_cnt  = cnt_sel - CNT_W'(1);
                    n_src    = wsde_pkg::SRC_STOLEN;
                    n_state  = ST_READ;
                end else if (r_arr_en && (cnt_arr != '0)) begin
                    mem_re   = 1'b1;
                    mem_addr = ARR_BASE + ADDR_W'(wrap_pos(
                        POS_W'(head_arr) + POS_W'(cnt_arr) - POS_W'(1)));
                    upd_en   = 1'b1;
                    upd_q    = ARR_Q;
                    upd_head = head_arr;
                    upd_cnt  = cnt_arr - CNT_W'(1);
                    n_src    = wsde_pkg::SRC_ARRIVAL;
                    n_state  = ST_READ;
                end else begin
                    n_out_valid = 1'b1;
                    n_out_job   = '0;
                    n_out_src   = wsde_pkg::SRC_NONE;
                    n_out_sts   = wsde_pkg::STS_NO_WORK;
                    n_state     = ST_IDLE;
                end
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_out_job   = r_mem_q;
                n_out_src   = r_src;
                n_out_sts   = wsde_pkg::STS_DONE;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_thr       <= wsde_pkg::STEAL_THR_RST;
            r_wiu       <= wsde_pkg::WORKERS_IN_USE_RST;
            r_arr_en    <= 1'b0;
            for (int i = 0; i < NUM_DEQ; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (upd_en) begin
                r_head[upd_q] <= upd_head;
                r_cnt[upd_q]  <= upd_cnt;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    wsde_pkg::CFG_STEAL_THRESHOLD: r_thr    <= i_cfg_data[wsde_pkg::THR_W-1:0];
                    wsde_pkg::CFG_WORKERS_IN_USE:  r_wiu    <= i_cfg_data[wsde_pkg::WIU_W-1:0];
                    wsde_pkg::CFG_ARRIVAL_ENABLE:  r_arr_en <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vic      <= n_vic;
        r_steal_ok <= n_steal_ok;
        r_src      <= n_src;
        r_out_job  <= n_out_job;
        r_out_src  <= n_out_src;
        r_out_sts  <= n_out_sts;
    end

    // Job storage: one port, written by pushes, read by pops with registered data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_job;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/work_stealing_deque_engine.sv]
// Work-stealing deque engine: one bounded ring deque of job ids per worker plus
// one shared arrival deque, all kept in a single-port job memory.
// Request channel (i_valid / o_stall): a transaction carries a push_tail,
// push_head or get_work request; it is taken at a rising edge with i_valid high
// and o_stall low. Result channel (o_valid / i_stall): every request yields one
// result transaction, taken at an edge with o_valid high and i_stall low.
// Configuration channel (i_cfg_valid / o_cfg_ready): ready is always high; write
// only while no request is outstanding.
// Each result is registered in the back end's output register. Pushes, rejected
// and unused requests are settled in its idle state; an own-deque pop goes on
// through the read state, a get_work that finds nothing through the steal state,
// and a steal or arrival pop through the steal state and then the read state.
// The back end takes a new command only in its idle state and the job memory has
// one port, so it cannot start a request before it is through with the last one.
// A two-entry command queue lets requests arrive while the back end works. When
// the receiver stalls, the result is held in the output register, the back end
// waits, and o_stall rises once the queue fills.
// Reset clears all deques to empty and restores the configuration defaults;
// the job memory itself is not cleared.

`default_nettype none

module work_stealing_deque_engine #(
    parameter int NUM_WORKERS = wsde_pkg::NUM_WORKERS_DEF,
    parameter int DEQUE_DEPTH = wsde_pkg::DEQUE_DEPTH_DEF,
    parameter int JOB_ID_BITS = wsde_pkg::JOB_ID_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Request channel.
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [wsde_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [wsde_pkg::QSEL_W-1:0]    i_queue_sel,
    input  wire logic [JOB_ID_BITS-1:0]         i_job_id,
    input  wire logic [wsde_pkg::WRK_W-1:0]     i_worker,
    input  wire logic [wsde_pkg::WRK_W-1:0]     i_victim,
    // Result channel.
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [JOB_ID_BITS-1:0]              o_out_job_id,
    output logic [wsde_pkg::SRC_W-1:0]          o_source,
    output logic [wsde_pkg::STS_W-1:0]          o_status,
    // Configuration write channel.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [wsde_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [wsde_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int QIDX_W = $clog2(NUM_WORKERS + 1);
    localparam int CMD_W  = $bits(wsde_pkg::t_ctl) + 2 * QIDX_W + JOB_ID_BITS;

    wsde_pkg::t_ctl          front_ctl;
    logic [QIDX_W-1:0]       front_q;
    logic [QIDX_W-1:0]       front_vic;
    logic [JOB_ID_BITS-1:0]  front_job;

    wsde_pkg::t_ctl          back_ctl;
    logic [QIDX_W-1:0]       back_q;
    logic [QIDX_W-1:0]       back_vic;
    logic [JOB_ID_BITS-1:0]  back_job;

    logic [CMD_W-1:0]        cmd_wdata;
    logic [CMD_W-1:0]        cmd_rdata;
    logic                    cmd_full;
    logic                    cmd_valid;
    logic                    cmd_pop;

    // Registers are plain flops with no side effects, so writes never wait.
    assign o_cfg_ready = 1'b1;

    // Front end: decodes the request and settles the index checks that need
    // no deque state.
    wsde_front #(
        .NUM_WORKERS (NUM_WORKERS),
        .JOB_ID_BITS (JOB_ID_BITS)
    ) u_front (
        .i_req_type  (i_req_type),
        .i_queue_sel (i_queue_sel),
        .i_job_id    (i_job_id),
        .i_worker    (i_worker),
        .i_victim    (i_victim),
        .o_ctl       (front_ctl),
        .o_q         (front_q),
        .o_vic       (front_vic),
        .o_job       (front_job)
    );

    // The decoded command waits here until the back end is ready for it.
    assign cmd_wdata = {front_ctl, front_q, front_vic, front_job};
    assign o_stall   = cmd_full;

    wsde_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (wsde_pkg::QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (cmd_wdata),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_data  (cmd_rdata)
    );

    assign {back_ctl, back_q, back_vic, back_job} = cmd_rdata;

    // Back end: owns the deque pointers, the job memory, the configuration and
    // the result register.
    wsde_back #(
        .NUM_WORKERS (NUM_WORKERS),
        .DEQUE_DEPTH (DEQUE_DEPTH),
        .JOB_ID_BITS (JOB_ID_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_ctl       (back_ctl),
        .i_q         (back_q),
        .i_vic       (back_vic),
        .i_job       (back_job),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_job       (o_out_job_id),
        .o_source    (o_source),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

[hw/rtl/wsde_checker.sv]
`default_nettype none

module wsde_checker #(
    parameter int JOB_ID_BITS = wsde_pkg::JOB_ID_BITS_DEF
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire logic [JOB_ID_BITS-1:0]      o_out_job_id,
    input wire logic [wsde_pkg::SRC_W-1:0]  o_source,
    input wire logic [wsde_pkg::STS_W-1:0]  o_status
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_job_id) &&
                               $stable(o_source) && $stable(o_status))
        else $error("stalled result changed");

    a_none_has_no_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_source == wsde_pkg::SRC_NONE) |-> o_out_job_id == '0)
        else $error("job id given without a source");

    a_failure_has_no_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != wsde_pkg::STS_DONE) |-> o_source == wsde_pkg::SRC_NONE)
        else $error("failed transaction names a source");

    a_source_means_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_source != wsde_pkg::SRC_NONE) |-> o_status == wsde_pkg::STS_DONE)
        else $error("job handed out without done status");

endmodule

bind work_stealing_deque_engine wsde_checker #(
    .JOB_ID_BITS (JOB_ID_BITS)
) u_wsde_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_job_id (o_out_job_id),
    .o_source     (o_source),
    .o_status     (o_status)
);

`default_nettype wire
